// ===== rtl/slms_pkg.sv =====
// ----------------------------------------------------------------------------
// slms_pkg
// Shared types and constants of the lift motion sequencer: register indexes,
// register reset values, lift phases, sequencer states and status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slms_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed register widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned DWELL_W = 16;
  localparam int unsigned LVL_W   = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UP_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_DWELL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOT_DWELL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOT_LEVEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_LVL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd7;

  // Register reset values
  localparam logic [SPEED_W-1:0] UP_MS_RST     = 16'd1000;
  localparam logic [SPEED_W-1:0] DOWN_MS_RST   = 16'd1000;
  localparam logic [DWELL_W-1:0] TOP_DWELL_RST = 16'd0;
  localparam logic [DWELL_W-1:0] BOT_DWELL_RST = 16'd0;
  localparam logic [LVL_W-1:0]   TOP_LVL_RST   = 8'd1;
  localparam logic [LVL_W-1:0]   BOT_LVL_RST   = 8'd0;
  localparam logic [LVL_W-1:0]   START_LVL_RST = 8'd0;
  localparam logic               ENABLE_RST    = 1'b1;

  // Phase visits per advance transfer
  localparam logic [2:0] MAX_VISITS = 3'd4;

  typedef enum logic [1:0] {
    PH_RISE   = 2'd0,
    PH_FALL   = 2'd1,
    PH_TOP    = 2'd2,
    PH_BOTTOM = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VISIT,
    ST_DIVIDE,
    ST_APPLY,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [SPEED_W-1:0] up_ms;
    logic [SPEED_W-1:0] down_ms;
    logic [DWELL_W-1:0] top_dwell;
    logic [DWELL_W-1:0] bot_dwell;
    logic [LVL_W-1:0]   top_lvl;
    logic [LVL_W-1:0]   bot_lvl;
    logic [LVL_W-1:0]   start_lvl;
    logic               enable;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturating event count
  function automatic logic [1:0] ev_inc(input logic [1:0] ev);
    return (ev == 2'd3) ? 2'd3 : ev + 2'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/slms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slms_cfg_regs
// Configuration register file, written one register per cycle by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slms_cfg_regs import slms_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_UP_MS:     cfg_d.up_ms     = cfg_data_i[SPEED_W-1:0];
        REG_DOWN_MS:   cfg_d.down_ms   = cfg_data_i[SPEED_W-1:0];
        REG_TOP_DWELL: cfg_d.top_dwell = cfg_data_i[DWELL_W-1:0];
        REG_BOT_DWELL: cfg_d.bot_dwell = cfg_data_i[DWELL_W-1:0];
        REG_TOP_LEVEL: cfg_d.top_lvl   = cfg_data_i[LVL_W-1:0];
        REG_BOT_LEVEL: cfg_d.bot_lvl   = cfg_data_i[LVL_W-1:0];
        REG_START_LVL: cfg_d.start_lvl = cfg_data_i[LVL_W-1:0];
        REG_ENABLE:    cfg_d.enable    = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_ms     <= UP_MS_RST;
      cfg_q.down_ms   <= DOWN_MS_RST;
      cfg_q.top_dwell <= TOP_DWELL_RST;
      cfg_q.bot_dwell <= BOT_DWELL_RST;
      cfg_q.top_lvl   <= TOP_LVL_RST;
      cfg_q.bot_lvl   <= BOT_LVL_RST;
      cfg_q.start_lvl <= START_LVL_RST;
      cfg_q.enable    <= ENABLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/slms_divider.sv =====
// ----------------------------------------------------------------------------
// slms_divider
// Iterative restoring divider, two quotient bits per cycle. Turns elapsed
// time into a height step: quotient = dividend / divisor, truncated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slms_divider import slms_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [SPEED_W-1:0]    divisor_i,
  output div_stat_t                  stat_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned Steps = (DIVIDEND_W + 1) / 2;
  localparam int unsigned PadW  = 2 * Steps;
  localparam int unsigned CntW  = (Steps > 1) ? $clog2(Steps) : 1;

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [PadW-1:0]     acc_q, acc_d;
  logic [SPEED_W-1:0]  rem_q, rem_d;
  logic [SPEED_W-1:0]  dvs_q;
  logic [SPEED_W:0]    sh1, sh2, dif1, dif2;
  logic [SPEED_W-1:0]  rem1;
  logic                q1, q2, last;

  // Two restoring steps; dividend bits shift out of acc, quotient bits in
  always_comb begin
    sh1  = {rem_q, acc_q[PadW-1]};
    dif1 = sh1 - {1'b0, dvs_q};
    q1   = (sh1 >= {1'b0, dvs_q});
    rem1 = q1 ? dif1[SPEED_W-1:0] : sh1[SPEED_W-1:0];
    sh2  = {rem1, acc_q[PadW-2]};
    dif2 = sh2 - {1'b0, dvs_q};
    q2   = (sh2 >= {1'b0, dvs_q});
    rem_d = q2 ? dif2[SPEED_W-1:0] : sh2[SPEED_W-1:0];
    acc_d = {acc_q[PadW-3:0], q1, q2};
  end

  assign last = (cnt_q == CntW'(Steps - 1));

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= PadW'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = acc_q[DIVIDEND_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/shuttle_lift_motion_sequencer.sv =====
// ----------------------------------------------------------------------------
// shuttle_lift_motion_sequencer
// Reciprocating lift: dwell at bottom, rise, dwell at top, fall, driven by
// elapsed-time transfers. Height is unsigned fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, kind_i, elapsed_ms_i): kind 0
//   advances the lift by elapsed_ms_i, kind 1 restarts it at start_level.
//   Output channel (out_valid_o / out_stall_i): one result per input transfer
//   with height, phase and the number of moved events.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i; write
//   only while no transfer is in flight.
// Sequencing:
//   A restart or frozen advance goes straight from idle to the done state,
//   which loads its result into the output register once that is free. An
//   advance that ends in a dwell passes through the visit state for each phase
//   visit, then to done. An advance that reaches a rise or fall makes up to
//   three dwell visits and the move visit, runs the divider, then picks up the
//   quotient, applies the move and loads the result. One item is in flight at
//   a time; in_stall_o is high from the input transfer until its result is
//   loaded.
// Reset: height at start_level, dwell at bottom (or top when top is below
//   start), all registers at their reset values.
// Stall: the result waits in the output register; the next item may already
//   be taken and worked on, and waits in its last state until the stage frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shuttle_lift_motion_sequencer import slms_pkg::*; #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned LEVEL_BITS = 8,
  parameter int unsigned TIME_BITS  = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]             cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]            cfg_data_i,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             kind_i,
  input  wire logic [TIME_BITS-1:0]             elapsed_ms_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [LEVEL_BITS+FRAC_BITS-1:0]       height_o,
  output logic [1:0]                            phase_o,
  output logic [1:0]                            moved_events_o
);

  localparam int unsigned HW  = LEVEL_BITS + FRAC_BITS;
  localparam int unsigned QW  = TIME_BITS + FRAC_BITS;
  localparam int unsigned AW  = ((HW > QW) ? HW : QW) + 1;
  localparam int unsigned DWW = (TIME_BITS > DWELL_W) ? TIME_BITS : DWELL_W;

  localparam logic [HW-1:0]      HeightRst = {LEVEL_BITS'(START_LVL_RST), FRAC_BITS'(0)};
  localparam phase_e             PhaseRst  =
      (LEVEL_BITS'(TOP_LVL_RST) < LEVEL_BITS'(START_LVL_RST)) ? PH_TOP : PH_BOTTOM;
  localparam logic [DWELL_W-1:0] DwellRst  =
      (LEVEL_BITS'(TOP_LVL_RST) < LEVEL_BITS'(START_LVL_RST)) ? TOP_DWELL_RST
                                                               : BOT_DWELL_RST;

  function automatic logic [HW-1:0] level_q(input logic [LVL_W-1:0] lvl);
    return {LEVEL_BITS'(lvl), FRAC_BITS'(0)};
  endfunction

  cfg_t                   cfg;
  seq_state_e             state_q, state_d;
  logic [HW-1:0]          height_q, height_d;
  phase_e                 phase_q, phase_d;
  logic [DWELL_W-1:0]     dwell_q, dwell_d;
  logic [TIME_BITS-1:0]   ms_q, ms_d;
  logic [LEVEL_BITS-1:0]  orig_q, orig_d;
  logic [2:0]             visits_q, visits_d;
  logic [1:0]             ev_q, ev_d;

  logic                   out_valid_q;
  logic [HW-1:0]          out_height_q;
  phase_e                 out_phase_q;
  logic [1:0]             out_ev_q;

  logic                   in_xfer, out_load, frozen, restart_top;
  logic [HW-1:0]          top_q, bot_q;
  logic                   div_start;
  logic [QW-1:0]          div_dividend, div_quot;
  logic [SPEED_W-1:0]     div_divisor, speed;
  div_stat_t              div_stat;
  logic [AW-1:0]          rise_h, fall_h;

  slms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Shared divider: (ms << FRAC_BITS) / ms_per_level
  assign speed        = (phase_q == PH_RISE) ? cfg.up_ms : cfg.down_ms;
  assign div_divisor  = (speed == '0) ? SPEED_W'(1) : speed;
  assign div_dividend = {ms_q, FRAC_BITS'(0)};

  slms_divider #(
    .DIVIDEND_W (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  assign top_q       = level_q(cfg.top_lvl);
  assign bot_q       = level_q(cfg.bot_lvl);
  assign frozen      = !cfg.enable || (top_q == bot_q && height_q == top_q);
  assign restart_top = LEVEL_BITS'(cfg.top_lvl) < LEVEL_BITS'(cfg.start_lvl);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign rise_h      = AW'(height_q) + AW'(div_quot);
  assign fall_h      = AW'(height_q) - AW'(div_quot);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (kind_i || frozen) ? ST_DONE : ST_VISIT;
        end
      end
      ST_VISIT: begin
        if (ms_q == '0 || visits_q == MAX_VISITS) begin
          state_d = ST_DONE;
        end else if (phase_q == PH_RISE || phase_q == PH_FALL) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and lift state update
  always_comb begin
    height_d  = height_q;
    phase_d   = phase_q;
    dwell_d   = dwell_q;
    ms_d      = ms_q;
    orig_d    = orig_q;
    visits_d  = visits_q;
    ev_d      = ev_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          ev_d     = '0;
          visits_d = '0;
          ms_d     = elapsed_ms_i;
          orig_d   = height_q[HW-1:FRAC_BITS];
          if (kind_i) begin
            height_d = level_q(cfg.start_lvl);
            phase_d  = restart_top ? PH_TOP : PH_BOTTOM;
            dwell_d  = restart_top ? cfg.top_dwell : cfg.bot_dwell;
          end
        end
      end
      ST_VISIT: begin
        if (ms_q != '0 && visits_q != MAX_VISITS) begin
          visits_d = visits_q + 3'd1;
          if (phase_q == PH_RISE || phase_q == PH_FALL) begin
            div_start = 1'b1;
          end else if (DWW'(ms_q) > DWW'(dwell_q)) begin
            // dwell over: carry the excess time
            ms_d = TIME_BITS'(DWW'(ms_q) - DWW'(dwell_q));
            if (phase_q == PH_TOP) begin
              if (height_q <= bot_q) begin
                phase_d = PH_BOTTOM;
                dwell_d = cfg.bot_dwell;
              end else begin
                phase_d = PH_FALL;
                dwell_d = '0;
              end
            end else begin
              if (height_q >= top_q) begin
                phase_d = PH_TOP;
                dwell_d = cfg.top_dwell;
              end else begin
                phase_d = PH_RISE;
                dwell_d = '0;
                ev_d    = ev_inc(ev_q);
              end
            end
          end else begin
            dwell_d = DWELL_W'(DWW'(dwell_q) - DWW'(ms_q));
            ms_d    = '0;
          end
        end
      end
      ST_APPLY: begin
        ms_d = '0;
        if (phase_q == PH_RISE) begin
          if (rise_h > AW'(top_q)) begin
            height_d = top_q;
            phase_d  = PH_TOP;
            dwell_d  = cfg.top_dwell;
          end else begin
            height_d = rise_h[HW-1:0];
            if (rise_h[HW-1:FRAC_BITS] != orig_q) begin
              ev_d = ev_inc(ev_q);
            end
          end
        end else begin
          if (fall_h[AW-1] || fall_h[HW-1:0] < bot_q) begin
            height_d = bot_q;
            phase_d  = PH_BOTTOM;
            dwell_d  = cfg.bot_dwell;
          end else begin
            height_d = fall_h[HW-1:0];
            if (fall_h[HW-1:FRAC_BITS] != orig_q) begin
              ev_d = ev_inc(ev_q);
            end
          end
        end
      end
      default: begin
        height_d = height_q;
      end
    endcase
  end

  // Control and lift state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      height_q <= HeightRst;
      phase_q  <= PhaseRst;
      dwell_q  <= DwellRst;
      visits_q <= '0;
      ev_q     <= '0;
    end else begin
      state_q  <= state_d;
      height_q <= height_d;
      phase_q  <= phase_d;
      dwell_q  <= dwell_d;
      visits_q <= visits_d;
      ev_q     <= ev_d;
    end
  end

  // Per-item working values
  always_ff @(posedge clk_i) begin
    ms_q   <= ms_d;
    orig_q <= orig_d;
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_height_q <= height_q;
      out_phase_q  <= phase_q;
      out_ev_q     <= ev_q;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign height_o       = out_height_q;
  assign phase_o        = out_phase_q;
  assign moved_events_o = out_ev_q;

  // Divider runs only while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == ST_DIVIDE)
    else $error("divider busy outside divide state");

  // Phase visits bounded per item
  a_visits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visits_q <= MAX_VISITS)
    else $error("too many phase visits");

  // No dwell time is held while moving
  a_move_dwell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RISE || phase_q == PH_FALL) |-> dwell_q == '0)
    else $error("dwell counter nonzero during a move");

  // At most one start event and one level change per item
  a_ev_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q != 2'd3)
    else $error("moved event count out of range");

  // Result load always hands the input side back
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !in_stall_o && out_valid_o)
    else $error("result load did not free the sequencer");

endmodule

`default_nettype wire
